@@ design/bfe_pkg.sv @@
package bfe_pkg;

	localparam int MantW = 28;

	// Operation codes
	localparam logic [1:0] OP_COPY  = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_MUL   = 2'd2;
	localparam logic [1:0] OP_SCALE = 2'd3;

	// Register indexes
	localparam int REG_SCALE = 0;

	localparam logic [15:0] BF_QNAN  = 16'h7fc0;
	localparam logic [15:0] BF_INF   = 16'h7f80;
	localparam logic [15:0] SCALE_RST = 16'h3f80;

	// Decoded operands, product or add operands
	typedef struct packed {
		logic               spec;
		logic [15:0]        spec_val;
		logic               is_mul;
		logic               sub;
		logic               sign;
		logic               zsign;
		logic signed [10:0] exp;
		logic [15:0]        prod;
		logic [7:0]         m_big;
		logic [7:0]         m_small;
		logic [7:0]         diff;
	} s1_t;

	// Unnormalized significand, binary point after bit 26
	typedef struct packed {
		logic               spec;
		logic [15:0]        spec_val;
		logic               sign;
		logic               zsign;
		logic signed [10:0] exp;
		logic [MantW-1:0]   mant;
	} s2_t;

	// Normalized significand ready for rounding
	typedef struct packed {
		logic             spec;
		logic [15:0]      spec_val;
		logic             sign;
		logic             zsign;
		logic             zero;
		logic             ovf;
		logic [7:0]       eb;
		logic [MantW-1:0] mant;
	} s3_t;

endpackage

@@ design/bf16_elementwise_add_mul_unit_top.sv @@
// channel   | handshake              | word
// ----------+------------------------+------------------------------------------
// request   | req_valid / req_stall  | operation, operand_a, operand_b, last_item
// response  | rsp_valid / rsp_stall  | result_value, last_out
// config    | APB psel/penable/...   | scale_factor at byte address 0
//
// Four register stages: decode and 8x8 product, align and add, normalize,
// round. One word enters per cycle while req_stall is low.
// Each stage advances when it is empty or the stage after it moves, so
// bubbles close up under a response stall. Reset empties the pipe and
// sets scale_factor to 1.0.
module bf16_elementwise_add_mul_unit_top import bfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  operation,
	input  logic [15:0] operand_a,
	input  logic [15:0] operand_b,
	input  logic        last_item,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [15:0] result_value,
	output logic        last_out
);

	logic [15:0] scale_q;
	logic [15:0] opb;
	s1_t         dec, st_s1;
	s2_t         al, st_s2;
	s3_t         nm, st_s3;
	logic [15:0] rnd, res_s4;
	logic        v_s1, v_s2, v_s3, v_s4;
	logic        l_s1, l_s2, l_s3, l_s4;
	logic        rdy1, rdy2, rdy3, rdy4;

	// config register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'(REG_SCALE)) ? {16'd0, scale_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
		end else if (psel && penable && pwrite && (paddr[2] == 1'(REG_SCALE))) begin
			scale_q <= pwdata[15:0];
		end
	end

	// stage logic
	assign opb = (operation == OP_SCALE) ? scale_q : operand_b;

	bfe_decode u_dec (.operation(operation), .opa(operand_a), .opb(opb), .dec(dec));
	bfe_align  u_al  (.in_w(st_s1), .out_w(al));
	bfe_norm   u_nm  (.in_w(st_s2), .out_w(nm));
	bfe_round  u_rnd (.in_w(st_s3), .res(rnd));

	// stage ready chain
	assign rdy4 = !v_s4 || !rsp_stall;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign req_stall = !rdy1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (rdy1) begin
			st_s1 <= dec;
			l_s1  <= last_item;
		end
		if (rdy2) begin
			st_s2 <= al;
			l_s2  <= l_s1;
		end
		if (rdy3) begin
			st_s3 <= nm;
			l_s3  <= l_s2;
		end
		if (rdy4) begin
			res_s4 <= rnd;
			l_s4   <= l_s3;
		end
	end

	assign rsp_valid    = v_s4;
	assign result_value = res_s4;
	assign last_out     = l_s4;

endmodule

@@ design/bfe_decode.sv @@
module bfe_decode import bfe_pkg::*; (
	input  logic [1:0]  operation,
	input  logic [15:0] opa,
	input  logic [15:0] opb,
	output s1_t         dec
);

	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
	logic [7:0]  xa, xb, ma, mb;
	logic        a_big;
	logic        is_mul;

	always_comb begin
		nan_a  = (opa[14:7] == 8'hff) && (opa[6:0] != 7'd0);
		nan_b  = (opb[14:7] == 8'hff) && (opb[6:0] != 7'd0);
		inf_a  = opa[14:0] == BF_INF[14:0];
		inf_b  = opb[14:0] == BF_INF[14:0];
		zero_a = opa[14:0] == 15'd0;
		zero_b = opb[14:0] == 15'd0;
		xa = (opa[14:7] == 8'd0) ? 8'd1 : opa[14:7];
		xb = (opb[14:7] == 8'd0) ? 8'd1 : opb[14:7];
		ma = {opa[14:7] != 8'd0, opa[6:0]};
		mb = {opb[14:7] != 8'd0, opb[6:0]};
		is_mul = (operation == OP_MUL) || (operation == OP_SCALE);
		a_big  = opa[14:0] >= opb[14:0];

		dec = '0;
		dec.is_mul = is_mul;
		dec.sub    = opa[15] ^ opb[15];

		// special results
		if (operation == OP_COPY) begin
			dec.spec = 1'b1;
			dec.spec_val = opa;
		end else if (nan_a) begin
			dec.spec = 1'b1;
			dec.spec_val = opa | BF_QNAN;
		end else if (nan_b) begin
			dec.spec = 1'b1;
			dec.spec_val = opb | BF_QNAN;
		end else if (is_mul) begin
			if ((inf_a && zero_b) || (zero_a && inf_b)) begin
				dec.spec = 1'b1;
				dec.spec_val = BF_QNAN;
			end else if (inf_a || inf_b) begin
				dec.spec = 1'b1;
				dec.spec_val = {opa[15] ^ opb[15], BF_INF[14:0]};
			end
		end else begin
			if (inf_a && inf_b && (opa[15] != opb[15])) begin
				dec.spec = 1'b1;
				dec.spec_val = BF_QNAN;
			end else if (inf_a) begin
				dec.spec = 1'b1;
				dec.spec_val = opa;
			end else if (inf_b) begin
				dec.spec = 1'b1;
				dec.spec_val = opb;
			end
		end

		// datapath operands
		if (is_mul) begin
			dec.sign  = opa[15] ^ opb[15];
			dec.zsign = opa[15] ^ opb[15];
			dec.exp   = $signed({3'b0, xa}) + $signed({3'b0, xb}) - 11'sd127;
			dec.prod  = {8'd0, ma} * {8'd0, mb};
		end else begin
			dec.sign    = a_big ? opa[15] : opb[15];
			dec.zsign   = dec.sub ? 1'b0 : opa[15];
			dec.exp     = $signed({3'b0, (a_big ? xa : xb)});
			dec.m_big   = a_big ? ma : mb;
			dec.m_small = a_big ? mb : ma;
			dec.diff    = a_big ? (xa - xb) : (xb - xa);
		end
	end

endmodule

@@ design/bfe_align.sv @@
module bfe_align import bfe_pkg::*; (
	input  s1_t in_w,
	output s2_t out_w
);

	logic [MantW-1:0] big, sm, sh;
	logic             sticky;

	always_comb begin
		big    = {1'b0, in_w.m_big, 19'd0};
		sm     = {1'b0, in_w.m_small, 19'd0};
		sh     = sm >> in_w.diff;
		sticky = (sh << in_w.diff) != sm;

		out_w.spec     = in_w.spec;
		out_w.spec_val = in_w.spec_val;
		out_w.sign     = in_w.sign;
		out_w.zsign    = in_w.zsign;
		out_w.exp      = in_w.exp;
		if (in_w.is_mul) begin
			out_w.mant = {in_w.prod, 12'd0};
		end else if (in_w.sub) begin
			out_w.mant = big - (sh | {27'd0, sticky});
		end else begin
			out_w.mant = big + (sh | {27'd0, sticky});
		end
	end

endmodule

@@ design/bfe_norm.sv @@
module bfe_norm import bfe_pkg::*; (
	input  s2_t in_w,
	output s3_t out_w
);

	logic [4:0]         lz;
	logic signed [11:0] er;
	logic               normal;
	logic [6:0]         rs;
	logic [MantW-1:0]   sh;

	always_comb begin
		// leading zero count, highest set bit wins
		lz = 5'd28;
		for (int i = 0; i < MantW; i++) begin
			if (in_w.mant[i]) lz = 5'(MantW - 1 - i);
		end
		er     = 12'(in_w.exp) + 12'sd1 - $signed({7'd0, lz});
		normal = er >= 12'sd1;
		rs     = 7'(-in_w.exp);
		sh     = in_w.mant >> rs[4:0];

		out_w.spec     = in_w.spec;
		out_w.spec_val = in_w.spec_val;
		out_w.sign     = in_w.sign;
		out_w.zsign    = in_w.zsign;
		out_w.zero     = in_w.mant == '0;
		out_w.ovf      = normal && (er >= 12'sd255);
		out_w.eb       = normal ? 8'(er - 12'sd1) : 8'd0;

		// left shift to hidden bit, or denormalize with sticky
		if (normal) begin
			out_w.mant = in_w.mant << lz;
		end else if (in_w.exp >= 11'sd0) begin
			out_w.mant = in_w.mant << in_w.exp[4:0];
		end else if (rs >= 7'd28) begin
			out_w.mant = {27'd0, |in_w.mant};
		end else begin
			out_w.mant = sh | {27'd0, (sh << rs[4:0]) != in_w.mant};
		end
	end

endmodule

@@ design/bfe_round.sv @@
module bfe_round import bfe_pkg::*; (
	input  s3_t         in_w,
	output logic [15:0] res
);

	logic [23:0] m24;
	logic        inc;
	logic [30:0] mag;
	logic [31:0] f32;
	logic [15:0] lo;

	always_comb begin
		// FP32 round to nearest even; carry runs into the exponent
		m24 = in_w.mant[27:4];
		inc = in_w.mant[3] & ((|in_w.mant[2:0]) | m24[0]);
		mag = {in_w.eb, 23'd0} + {7'd0, m24} + {30'd0, inc};
		f32 = in_w.ovf ? {in_w.sign, 8'hff, 23'd0} : {in_w.sign, mag};
		lo  = f32[15:0];

		// FP32 to BF16, round to nearest even
		if (in_w.spec) begin
			res = in_w.spec_val;
		end else if (in_w.zero) begin
			res = {in_w.zsign, 15'd0};
		end else if (f32[30:23] == 8'hff) begin
			res = f32[31:16];
		end else if ((lo > 16'h8000) || ((lo == 16'h8000) && f32[16])) begin
			res = f32[31:16] + 16'd1;
		end else begin
			res = f32[31:16];
		end
	end

endmodule
